// ----- rtl/normalized_image_convolution_core_defines.svh -----
// Assertion macros shared by the convolution core.
`ifndef NORMALIZED_IMAGE_CONVOLUTION_CORE_DEFINES_SVH
`define NORMALIZED_IMAGE_CONVOLUTION_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define NIC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NIC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NIC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/nic_pkg.sv -----
// Shared types and constants of the convolution core.
`timescale 1ns / 1ps
package nic_pkg;
  localparam int ACC_W    = 21;
  localparam int NORM_W   = 12;
  localparam int DVD_W    = 28;
  localparam int VALUE_W  = 17;
  localparam int ROW_W    = 10;
  localparam int DIM_W    = 11;

  localparam logic [2:0] REG_KSEL   = 3'd0;
  localparam logic [2:0] REG_BMODE  = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COEF_A = 3'd4;
  localparam logic [2:0] REG_COEF_B = 3'd5;
  localparam logic [2:0] REG_COEF_C = 3'd6;
  localparam logic [2:0] REG_COEF_D = 3'd7;

  typedef logic [24:0][7:0] coef_arr_t;

  typedef struct packed {
    logic accept;
    logic tap_clr;
    logic tap_en;
    logic div_load;
    logic div_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic mac_last;
    logic div_last;
    logic out_free;
  } sts_t;
endpackage

// ----- rtl/nic_ram.sv -----
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module nic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- rtl/nic_ctrl.sv -----
// Sequencer: accept, tap loop, serial divide, result hand-off.
`timescale 1ns / 1ps
module nic_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nic_pkg::sts_t sts_i,
  output nic_pkg::cmd_t cmd_o
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DIVI  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.emit) begin
          cmd_o.tap_clr = 1'b1;
          state_d = ST_MAC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd_o.tap_en = 1'b1;
        if (sts_i.mac_last) state_d = ST_DIVI;
      end
      ST_DIVI: begin
        cmd_o.div_load = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        if (sts_i.div_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
endmodule

// ----- rtl/nic_datapath.sv -----
// Frame counters, line store, tap MAC, serial divider and output register.
`timescale 1ns / 1ps
module nic_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nic_pkg::cmd_t                   cmd_i,
  output nic_pkg::sts_t                   sts_o,
  input  logic                            mode_i,
  input  logic [7:0]                      pixel_i,
  input  logic                            ksel_i,
  input  logic                            bmode_i,
  input  logic [nic_pkg::DIM_W-1:0]       width_i,
  input  logic [nic_pkg::DIM_W-1:0]       height_i,
  input  nic_pkg::coef_arr_t              coef_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic signed [nic_pkg::VALUE_W-1:0] value_o,
  output logic [nic_pkg::ROW_W-1:0]       out_row_o,
  output logic [nic_pkg::ROW_W-1:0]       out_col_o,
  output logic                            frame_last_o,
  output logic                            zero_norm_o
);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = COL_W + 3;
  localparam int DEPTH  = 8 << COL_W;
  localparam int WTOP   = MAX_WIDTH < 1024 ? MAX_WIDTH : 1024;
  localparam int HTOP   = MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024;
  localparam logic [nic_pkg::DIM_W-1:0] WTOP_V = nic_pkg::DIM_W'(WTOP);
  localparam logic [nic_pkg::DIM_W-1:0] HTOP_V = nic_pkg::DIM_W'(HTOP);
  localparam logic [nic_pkg::DIM_W-1:0] DIM_MIN = nic_pkg::DIM_W'(5);
  localparam logic BIG_OK = (MAX_KERNEL >= 5);

  // frame state
  logic                      active_q, done_q, rad2_q, rep_q, emit_q;
  logic [nic_pkg::DIM_W-1:0] fr_w_q, fr_h_q;
  logic [9:0]                in_row_q, in_col_q, out_row_q, out_col_q;
  logic [20:0]               in_lin_q, out_lin_q;

  logic                      start, active_e, done_e, rad2_e, wr;
  logic [nic_pkg::DIM_W-1:0] w_e, h_e, w_clamp, h_clamp;
  logic [11:0]               lag_e;
  logic [9:0]                in_row_e, in_col_e;
  logic [20:0]               in_lin_e, out_lin_e, in_lin_n;
  logic [10:0]               col_inc, row_inc;
  logic                      emit_d;

  always_comb begin
    w_clamp = width_i < DIM_MIN ? DIM_MIN : (width_i > WTOP_V ? WTOP_V : width_i);
    h_clamp = height_i < DIM_MIN ? DIM_MIN : (height_i > HTOP_V ? HTOP_V : height_i);
    start    = !mode_i && !active_q;
    active_e = active_q || start;
    done_e   = start ? 1'b0 : done_q;
    w_e      = start ? w_clamp : fr_w_q;
    h_e      = start ? h_clamp : fr_h_q;
    rad2_e   = start ? (ksel_i && BIG_OK) : rad2_q;
    lag_e    = rad2_e ? ({w_e, 1'b0} + 12'd2) : ({1'b0, w_e} + 12'd1);
    in_row_e = start ? '0 : in_row_q;
    in_col_e = start ? '0 : in_col_q;
    in_lin_e = start ? '0 : in_lin_q;
    out_lin_e = start ? '0 : out_lin_q;
    wr       = cmd_i.accept && !mode_i && !done_e;
    col_inc  = {1'b0, in_col_e} + 11'd1;
    row_inc  = {1'b0, in_row_e} + 11'd1;
    in_lin_n = in_lin_e + 21'd1;
    if (wr) begin
      emit_d = {1'b0, in_lin_n} >= ({1'b0, out_lin_e} + 22'(lag_e) + 22'd1);
    end else begin
      emit_d = active_e && done_e;
    end
  end

  // tap loop
  logic [4:0]        t_q;
  logic [2:0]        kx_q, ky_q;
  logic              rd_vld_q;
  logic signed [7:0] coef_d1_q;
  logic signed [nic_pkg::ACC_W-1:0] acc_q;
  logic [nic_pkg::NORM_W-1:0]       norm_q;
  logic [4:0]        kk;
  logic [2:0]        kmax;
  logic              issue;
  logic signed [7:0] coef_sel;
  logic [7:0]        coef_abs;
  logic signed [11:0] ys, xs, rad_s;
  logic [9:0]        y_c, x_c;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [7:0]        rdata;
  logic signed [16:0] prod;

  always_comb begin
    kk       = rad2_q ? 5'd25 : 5'd9;
    kmax     = rad2_q ? 3'd4 : 3'd2;
    issue    = cmd_i.tap_en && (t_q < kk);
    coef_sel = (t_q <= 5'd24) ? $signed(coef_i[t_q]) : 8'sd0;
    coef_abs = coef_sel[7] ? (~coef_sel + 8'd1) : coef_sel;
    rad_s    = rad2_q ? 12'sd2 : 12'sd1;
    ys = $signed({2'b00, out_row_q}) + $signed({9'd0, ky_q}) - rad_s;
    xs = $signed({2'b00, out_col_q}) + $signed({9'd0, kx_q}) - rad_s;
    if (ys < 12'sd0) y_c = '0;
    else if (ys > $signed({1'b0, fr_h_q} - 12'd1)) y_c = 10'(fr_h_q - 11'd1);
    else y_c = ys[9:0];
    if (xs < 12'sd0) x_c = '0;
    else if (xs > $signed({1'b0, fr_w_q} - 12'd1)) x_c = 10'(fr_w_q - 11'd1);
    else x_c = xs[9:0];
    raddr = {y_c[2:0], COL_W'(x_c)};
    waddr = {in_row_e[2:0], COL_W'(in_col_e)};
    prod  = $signed({1'b0, rdata}) * coef_d1_q;
  end

  // rows are kept modulo eight, so the whole window stays resident
  nic_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (waddr),
    .wdata_i (pixel_i),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // restoring divider
  logic [nic_pkg::DVD_W-1:0]  dvd_q;
  logic [nic_pkg::NORM_W-1:0] rem_q;
  logic [4:0]                 dcnt_q;
  logic                       neg_q;
  logic [nic_pkg::NORM_W:0]   rem_sh;
  logic                       ge;
  logic [nic_pkg::ACC_W-1:0]  mag;

  always_comb begin
    rem_sh = {rem_q, dvd_q[nic_pkg::DVD_W-1]};
    ge     = rem_sh >= {1'b0, norm_q};
    mag    = acc_q[nic_pkg::ACC_W-1] ? 21'(-acc_q) : acc_q;
  end

  // result geometry
  logic [9:0]  rad_u;
  logic        in_frame, last;
  logic [16:0] quo;
  always_comb begin
    rad_u  = rad2_q ? 10'd2 : 10'd1;
    in_frame = (out_row_q >= rad_u) && (out_col_q >= rad_u) &&
               (({1'b0, out_row_q} + {1'b0, rad_u}) < fr_h_q) &&
               (({1'b0, out_col_q} + {1'b0, rad_u}) < fr_w_q);
    last   = (({1'b0, out_row_q} + 11'd1) == fr_h_q) &&
             (({1'b0, out_col_q} + 11'd1) == fr_w_q);
    quo    = dvd_q[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      done_q      <= 1'b0;
      rad2_q      <= 1'b0;
      rep_q       <= 1'b1;
      emit_q      <= 1'b0;
      fr_w_q      <= DIM_MIN;
      fr_h_q      <= DIM_MIN;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_lin_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_lin_q   <= '0;
      t_q         <= '0;
      kx_q        <= '0;
      ky_q        <= '0;
      rd_vld_q    <= 1'b0;
      dcnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        emit_q   <= emit_d;
        active_q <= active_e;
        if (start) begin
          fr_w_q    <= w_e;
          fr_h_q    <= h_e;
          rad2_q    <= rad2_e;
          rep_q     <= bmode_i;
          out_row_q <= '0;
          out_col_q <= '0;
          out_lin_q <= '0;
        end
        if (wr) begin
          in_lin_q <= in_lin_n;
          if (col_inc >= w_e) begin
            in_col_q <= '0;
            in_row_q <= row_inc[9:0];
            done_q   <= row_inc >= h_e;
          end else begin
            in_col_q <= col_inc[9:0];
            in_row_q <= in_row_e;
            done_q   <= done_e;
          end
        end else if (start) begin
          in_row_q <= '0;
          in_col_q <= '0;
          in_lin_q <= '0;
          done_q   <= 1'b0;
        end
      end
      if (cmd_i.tap_clr) begin
        t_q      <= '0;
        kx_q     <= '0;
        ky_q     <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.tap_en) begin
        rd_vld_q <= issue;
        if (issue) begin
          t_q <= t_q + 5'd1;
          if (kx_q == kmax) begin
            kx_q <= '0;
            ky_q <= ky_q + 3'd1;
          end else begin
            kx_q <= kx_q + 3'd1;
          end
        end
      end
      if (cmd_i.div_load) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_en) begin
        dcnt_q <= dcnt_q + 5'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
        if (last) begin
          active_q  <= 1'b0;
          done_q    <= 1'b0;
          in_row_q  <= '0;
          in_col_q  <= '0;
          in_lin_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
          out_lin_q <= '0;
        end else begin
          out_lin_q <= out_lin_q + 21'd1;
          if (({1'b0, out_col_q} + 11'd1) >= fr_w_q) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 10'd1;
          end else begin
            out_col_q <= out_col_q + 10'd1;
          end
        end
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_clr) begin
      acc_q  <= '0;
      norm_q <= '0;
    end else if (cmd_i.tap_en) begin
      if (issue) begin
        norm_q    <= norm_q + nic_pkg::NORM_W'(coef_abs);
        coef_d1_q <= coef_sel;
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + nic_pkg::ACC_W'(prod);
      end
    end
    if (cmd_i.div_load) begin
      neg_q <= acc_q[nic_pkg::ACC_W-1];
      dvd_q <= {mag[19:0], 8'd0};
      rem_q <= '0;
    end else if (cmd_i.div_en) begin
      rem_q <= ge ? nic_pkg::NORM_W'(rem_sh - {1'b0, norm_q})
                  : rem_sh[nic_pkg::NORM_W-1:0];
      dvd_q <= {dvd_q[nic_pkg::DVD_W-2:0], ge};
    end
    if (cmd_i.out_load) begin
      if ((norm_q == '0) || (!rep_q && !in_frame)) value_o <= '0;
      else value_o <= neg_q ? $signed(-quo) : $signed(quo);
      out_row_o    <= out_row_q;
      out_col_o    <= out_col_q;
      frame_last_o <= last;
      zero_norm_o  <= (norm_q == '0);
    end
  end

  assign sts_o.emit     = emit_q;
  assign sts_o.mac_last = (t_q == kk);
  assign sts_o.div_last = (dcnt_q == 5'(nic_pkg::DVD_W - 1));
  assign sts_o.out_free = !out_valid_o || !out_stall_i;
endmodule

// ----- rtl/normalized_image_convolution_core.sv -----
// Sequence: a request that releases a result passes the check, tap, divide-load, divide and
// output states before result valid; one that releases nothing frees the input after the check.
// Throughput: one request at a time; the next is taken once the output register has taken the
// result, which waits while the output stalls; set by one tap a cycle from the single
// line store read port and the 28-step serial divider.
// Reset: asynchronous, active low; frame state clears, registers take defaults, store kept.
`timescale 1ns / 1ps
`include "normalized_image_convolution_core_defines.svh"
module normalized_image_convolution_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [16:0] value_o,
  output logic [9:0]  out_row_o,
  output logic [9:0]  out_col_o,
  output logic        frame_last_o,
  output logic        zero_norm_o
);
  logic        ksel_q, bmode_q;
  logic [10:0] width_q, height_q;
  logic [63:0] coef_a_q, coef_b_q, coef_c_q;
  logic [7:0]  coef_d_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q   <= 1'b0;
      bmode_q  <= 1'b1;
      width_q  <= 11'd640;
      height_q <= 11'd480;
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        nic_pkg::REG_KSEL:   ksel_q   <= pwdata[0];
        nic_pkg::REG_BMODE:  bmode_q  <= pwdata[0];
        nic_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
        nic_pkg::REG_HEIGHT: height_q <= pwdata[10:0];
        nic_pkg::REG_COEF_A: coef_a_q <= pwdata;
        nic_pkg::REG_COEF_B: coef_b_q <= pwdata;
        nic_pkg::REG_COEF_C: coef_c_q <= pwdata;
        nic_pkg::REG_COEF_D: coef_d_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nic_pkg::REG_KSEL:   prdata = {63'd0, ksel_q};
      nic_pkg::REG_BMODE:  prdata = {63'd0, bmode_q};
      nic_pkg::REG_WIDTH:  prdata = {53'd0, width_q};
      nic_pkg::REG_HEIGHT: prdata = {53'd0, height_q};
      nic_pkg::REG_COEF_A: prdata = coef_a_q;
      nic_pkg::REG_COEF_B: prdata = coef_b_q;
      nic_pkg::REG_COEF_C: prdata = coef_c_q;
      nic_pkg::REG_COEF_D: prdata = {56'd0, coef_d_q};
      default:             prdata = '0;
    endcase
  end

  nic_pkg::coef_arr_t coefs;
  assign coefs = {coef_d_q, coef_c_q, coef_b_q, coef_a_q};

  nic_pkg::cmd_t cmd;
  nic_pkg::sts_t sts;

  nic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nic_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .pixel_i      (pixel_i),
    .ksel_i       (ksel_q),
    .bmode_i      (bmode_q),
    .width_i      (width_q),
    .height_i     (height_q),
    .coef_i       (coefs),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o),
    .zero_norm_o  (zero_norm_o)
  );

  // one request in flight: busy right after an accept
  `NIC_ASSERT(a_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "busy")
  `NIC_ASSERT(a_zn, clk_i, rst_ni, out_valid_o && zero_norm_o |-> value_o == 17'sd0, "zero kernel")
  `NIC_ASSERT(a_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "no work")
endmodule
